@@ design/sre_pkg.sv @@
// Package for the spike rate encoder: sizes, codes, FSM state type and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package sre_pkg;

  // Neuron store geometry.
  localparam int NEURONS   = 2048;
  localparam int NEURON_AW = $clog2(NEURONS);

  // Fixed field widths of the ports.
  localparam int IDX_W    = 11;
  localparam int WORD_W   = 28;
  localparam int ACT_W    = 16;
  localparam int TIME_W   = 32;
  localparam int POT_W    = 20;
  localparam int CFG_W    = 16;
  localparam int CFG_IW   = 3;
  localparam int CHIP_W   = 8;
  localparam int CORE_W   = 12;
  localparam int AXON_W   = 14;
  localparam int AXWORD_W = 16;
  localparam int EPOCH_W  = 8;
  localparam int THR_W    = 16;
  localparam int NPC_W    = 11;
  localparam int CSTART_W = 7;

  // Packing of activations in a load_packed word.
  localparam int FIELD_BITS      = 7;
  localparam int FIELDS_PER_WORD = 4;
  localparam int FLD_CW          = $clog2(FIELDS_PER_WORD + 1);
  localparam logic [WORD_W-1:0] FIELD_MASK = WORD_W'((64'd1 << FIELD_BITS) - 64'd1);

  // Bias spikes.
  localparam int BIAS_COUNT = 3;
  localparam int BIAS_CW    = $clog2(BIAS_COUNT + 1);
  localparam logic [CHIP_W-1:0] BIAS_CHIP = CHIP_W'(0);

  // Event encoding constants.
  localparam logic [CORE_W-1:0]   CORE_BASE = CORE_W'(4);
  localparam logic [AXWORD_W-1:0] AXON_FLAG = AXWORD_W'(1 << 14);
  localparam logic [EPOCH_W-1:0]  WINDOW    = EPOCH_W'(5);
  localparam logic [POT_W-1:0]    POT_MAX   = {POT_W{1'b1}};

  // Iterative divider sizes.
  localparam int DVD_W = 32;
  localparam int DSR_W = 11;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  typedef enum logic [1:0] {
    ACT_LOAD_PACKED = 2'd0,
    ACT_LOAD_RAW    = 2'd1,
    ACT_NEURON_STEP = 2'd2,
    ACT_BIAS_STEP   = 2'd3
  } action_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_EPOCH_LENGTH    = 3'd0,
    REG_SPIKE_THRESHOLD = 3'd1,
    REG_NEURONS_PER_CORE = 3'd2,
    REG_INPUT_CORE_START = 3'd3,
    REG_INPUT_AXON_START = 3'd4,
    REG_INPUT_CHIP      = 3'd5,
    REG_BIAS_CORE       = 3'd6,
    REG_BIAS_AXON_START = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_PHASE,
    ST_PHASE_WAIT,
    ST_DECIDE,
    ST_UPDATE,
    ST_CORE,
    ST_CORE_WAIT,
    ST_EMIT,
    ST_BIAS
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic clear_wr;
    logic load_wr;
    logic div_phase;
    logic div_core;
    logic phase_take;
    logic pot_update;
    logic emit_neuron;
    logic emit_bias;
    logic bias_next;
  } sre_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    action_t action;
    logic    clear_last;
    logic    load_last;
    logic    div_busy;
    logic    in_window;
    logic    spike;
    logic    out_free;
    logic    bias_hit;
    logic    bias_last;
  } sre_status_t;

endpackage

`default_nettype wire

@@ design/sre_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
// Depends on sre_pkg for its widths.
`default_nettype none

module sre_div
  import sre_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [DSR_W-1:0]  divisor,
  input  wire logic [DCNT_W-1:0] steps,
  output logic                   busy,
  output logic [DVD_W-1:0]       quotient,
  output logic [DSR_W-1:0]       remainder
);

  logic [DVD_W-1:0]  dvd;
  logic [DSR_W-1:0]  dsr;
  logic [DSR_W-1:0]  rem;
  logic [DCNT_W-1:0] count;
  logic [DSR_W:0]    rem_shift;
  logic              fits;

  // One trial subtraction per step.
  always_comb begin
    rem_shift = {rem, dvd[DVD_W-1]};
    fits      = rem_shift >= {1'b0, dsr};
  end

  // The step counter is control state; the operands are not reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= steps;
    end else if (busy) begin
      count <= count - DCNT_W'(1);
    end
  end

  // Shift the quotient bits into the low end of the dividend register.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      rem <= fits ? DSR_W'(rem_shift - {1'b0, dsr}) : DSR_W'(rem_shift);
    end
  end

  assign busy      = (count != '0);
  assign quotient  = dvd;
  assign remainder = rem;

endmodule

`default_nettype wire

@@ design/sre_ctrl.sv @@
// Sequencing state machine of the spike rate encoder.
// Depends on sre_pkg for the state type and the command/status structs.
`default_nettype none

module sre_ctrl
  import sre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sre_status_t st,
  output sre_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (st.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (st.action == ACT_LOAD_PACKED || st.action == ACT_LOAD_RAW) begin
          state_next = ST_LOAD;
        end else begin
          state_next = ST_PHASE;
        end
      end
      ST_LOAD: begin
        if (st.load_last) state_next = ST_IDLE;
      end
      ST_PHASE: state_next = ST_PHASE_WAIT;
      ST_PHASE_WAIT: begin
        if (!st.div_busy) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (st.action == ACT_BIAS_STEP) begin
          state_next = ST_BIAS;
        end else if (st.in_window) begin
          state_next = ST_UPDATE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        state_next = st.spike ? ST_CORE : ST_IDLE;
      end
      ST_CORE: state_next = ST_CORE_WAIT;
      ST_CORE_WAIT: begin
        if (!st.div_busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      ST_BIAS: begin
        if (st.bias_last && (!st.bias_hit || st.out_free)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DISPATCH: ;
      ST_LOAD: cmd.load_wr = 1'b1;
      ST_PHASE: cmd.div_phase = 1'b1;
      ST_PHASE_WAIT: cmd.phase_take = !st.div_busy;
      ST_DECIDE: ;
      ST_UPDATE: cmd.pot_update = 1'b1;
      ST_CORE: cmd.div_core = st.spike;
      ST_CORE_WAIT: ;
      ST_EMIT: cmd.emit_neuron = st.out_free;
      ST_BIAS: begin
        // A masked-out bias slot is skipped without waiting on the output.
        cmd.emit_bias = st.bias_hit && st.out_free;
        cmd.bias_next = !st.bias_hit || st.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/sre_dp.sv @@
// Datapath of the spike rate encoder: configuration registers, item
// registers, neuron stores, divider and output register.
// Depends on sre_pkg and instantiates sre_div.
`default_nettype none

module sre_dp
  import sre_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sre_cmd_t             cmd,
  output sre_status_t               st,
  // Configuration writes.
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IW-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Input item fields.
  input  wire logic [1:0]           action,
  input  wire logic [IDX_W-1:0]     neuron_index,
  input  wire logic [WORD_W-1:0]    packed_word,
  input  wire logic [ACT_W-1:0]     raw_activation,
  input  wire logic [TIME_W-1:0]    sim_time,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [TIME_W-1:0]         event_time,
  output logic [CHIP_W-1:0]         chip_index,
  output logic [CORE_W-1:0]         core_id,
  output logic [AXWORD_W-1:0]       axon_word,
  output logic                      last_event
);

  // Configuration registers.
  logic [EPOCH_W-1:0]  epoch_length;
  logic [THR_W-1:0]    spike_threshold;
  logic [NPC_W-1:0]    neurons_per_core;
  logic [CSTART_W-1:0] input_core_start;
  logic [AXON_W-1:0]   input_axon_start;
  logic [CHIP_W-1:0]   input_chip;
  logic [CSTART_W-1:0] bias_core;
  logic [AXON_W-1:0]   bias_axon_start;

  // Captured item.
  action_t             act_reg;
  logic [IDX_W-1:0]    idx_reg;
  logic [WORD_W-1:0]   word_reg;
  logic [ACT_W-1:0]    raw_reg;
  logic [TIME_W-1:0]   time_reg;

  // Sequencing counters and phase.
  logic [NEURON_AW-1:0] clr_addr;
  logic [FLD_CW-1:0]    ld_j;
  logic [BIAS_CW-1:0]   bias_i;
  logic [EPOCH_W-1:0]   phase;

  // Neuron stores.
  logic [ACT_W-1:0] act_mem [NEURONS];
  logic [POT_W-1:0] pot_mem [NEURONS];
  logic [ACT_W-1:0] act_rd;
  logic [POT_W-1:0] pot_rd;

  // Divider.
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic [DSR_W-1:0]  div_divisor;
  logic [DCNT_W-1:0] div_steps;
  logic              div_busy;
  logic [DVD_W-1:0]  div_quot;
  logic [DSR_W-1:0]  div_rem;

  // Combinational helpers.
  logic [IDX_W:0]       ld_sum;
  logic                 ld_in_range;
  logic [ACT_W-1:0]     ld_value;
  logic [NEURON_AW-1:0] wr_addr;
  logic                 wr_act;
  logic                 wr_pot;
  logic [ACT_W-1:0]     wr_act_data;
  logic [POT_W-1:0]     wr_pot_data;
  logic                 spike;
  logic [POT_W:0]       pot_sum;
  logic [POT_W-1:0]     pot_new;
  logic [BIAS_COUNT-1:0] bias_mask;
  logic [BIAS_COUNT-1:0] bias_rest;
  logic [IDX_W-1:0]     core_q;
  logic [IDX_W-1:0]     axon_r;
  logic                 out_free;

  // Configuration writes may land at any time.
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_length     <= EPOCH_W'(9);
      spike_threshold  <= THR_W'(99);
      neurons_per_core <= NPC_W'(222);
      input_core_start <= '0;
      input_axon_start <= '0;
      input_chip       <= '0;
      bias_core        <= CSTART_W'(5);
      bias_axon_start  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EPOCH_LENGTH:     epoch_length     <= cfg_data[EPOCH_W-1:0];
        REG_SPIKE_THRESHOLD:  spike_threshold  <= cfg_data[THR_W-1:0];
        REG_NEURONS_PER_CORE: neurons_per_core <= cfg_data[NPC_W-1:0];
        REG_INPUT_CORE_START: input_core_start <= cfg_data[CSTART_W-1:0];
        REG_INPUT_AXON_START: input_axon_start <= cfg_data[AXON_W-1:0];
        REG_INPUT_CHIP:       input_chip       <= cfg_data[CHIP_W-1:0];
        REG_BIAS_CORE:        bias_core        <= cfg_data[CSTART_W-1:0];
        REG_BIAS_AXON_START:  bias_axon_start  <= cfg_data[AXON_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture on the input transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_reg  <= action_t'(action);
      idx_reg  <= neuron_index;
      word_reg <= packed_word;
      raw_reg  <= raw_activation;
      time_reg <= sim_time;
    end
  end

  // Counters for the clearing pass, load fields and bias slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      ld_j     <= '0;
      bias_i   <= '0;
    end else begin
      if (cmd.clear_wr) clr_addr <= clr_addr + NEURON_AW'(1);
      if (cmd.capture) begin
        ld_j   <= '0;
        bias_i <= '0;
      end else begin
        if (cmd.load_wr)   ld_j   <= ld_j + FLD_CW'(1);
        if (cmd.bias_next) bias_i <= bias_i + BIAS_CW'(1);
      end
    end
  end

  // Phase of the timestep within the epoch; zero epoch gives phase zero.
  always_ff @(posedge clk) begin
    if (cmd.phase_take) begin
      phase <= (epoch_length == '0) ? '0 : div_rem[EPOCH_W-1:0];
    end
  end

  // Load field selection and store write port.
  always_comb begin
    ld_sum      = {1'b0, idx_reg} + (IDX_W + 1)'(ld_j);
    ld_in_range = 32'(ld_sum) < NEURONS;
    if (act_reg == ACT_LOAD_RAW) begin
      ld_value = raw_reg;
    end else begin
      ld_value = ACT_W'((word_reg >> (int'(ld_j) * FIELD_BITS)) & FIELD_MASK);
    end

    spike   = pot_rd > POT_W'(spike_threshold);
    pot_sum = (spike ? {1'b0, pot_rd} - (POT_W + 1)'(spike_threshold) : {1'b0, pot_rd})
              + (POT_W + 1)'(act_rd);
    pot_new = pot_sum[POT_W] ? POT_MAX : pot_sum[POT_W-1:0];

    wr_addr     = idx_reg[NEURON_AW-1:0];
    wr_act      = 1'b0;
    wr_pot      = 1'b0;
    wr_act_data = '0;
    wr_pot_data = '0;
    priority if (cmd.clear_wr) begin
      wr_addr = clr_addr;
      wr_act  = 1'b1;
      wr_pot  = 1'b1;
    end else if (cmd.load_wr) begin
      wr_addr     = ld_sum[NEURON_AW-1:0];
      wr_act      = ld_in_range;
      wr_pot      = ld_in_range;
      wr_act_data = ld_value;
      wr_pot_data = POT_W'(ld_value);
    end else if (cmd.pot_update) begin
      wr_pot      = 1'b1;
      wr_pot_data = pot_new;
    end else begin
      wr_addr = idx_reg[NEURON_AW-1:0];
    end
  end

  // Neuron stores: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (wr_act) act_mem[wr_addr] <= wr_act_data;
    act_rd <= act_mem[idx_reg[NEURON_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_pot) pot_mem[wr_addr] <= wr_pot_data;
    pot_rd <= pot_mem[idx_reg[NEURON_AW-1:0]];
  end

  // Divider operands: timestep by epoch, or neuron index by neurons per core.
  always_comb begin
    div_start = cmd.div_phase | cmd.div_core;
    if (cmd.div_phase) begin
      div_dividend = time_reg;
      div_divisor  = DSR_W'(epoch_length);
      div_steps    = DCNT_W'(DVD_W);
    end else begin
      div_dividend = {idx_reg, {(DVD_W - IDX_W){1'b0}}};
      div_divisor  = neurons_per_core;
      div_steps    = DCNT_W'(IDX_W);
    end
  end

  sre_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .busy      (div_busy),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Bias windows, one per slot, and the window bits of the slots still left.
  always_comb begin
    for (int i = 0; i < BIAS_COUNT; i++) begin
      bias_mask[i] = ({1'b0, phase} > (EPOCH_W + 1)'(i)) &&
                     ({1'b0, phase} <= (EPOCH_W + 1)'(i) + (EPOCH_W + 1)'(WINDOW));
    end
    bias_rest = bias_mask >> bias_i;
  end

  // Destination of an input spike; zero neurons per core maps to core offset zero.
  always_comb begin
    core_q = (neurons_per_core == '0) ? '0 : div_quot[IDX_W-1:0];
    axon_r = (neurons_per_core == '0) ? idx_reg : IDX_W'(div_rem);
  end

  assign out_free = !out_valid || out_ready;

  // Output register; the receiver may stall it while a new item is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_neuron || cmd.emit_bias) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_neuron) begin
      event_time <= time_reg;
      chip_index <= input_chip;
      core_id    <= CORE_BASE + CORE_W'(input_core_start) + CORE_W'(core_q);
      axon_word  <= AXON_FLAG | AXWORD_W'(AXON_W'(input_axon_start + AXON_W'(axon_r)));
      last_event <= 1'b1;
    end else if (cmd.emit_bias) begin
      event_time <= time_reg;
      chip_index <= BIAS_CHIP;
      core_id    <= CORE_BASE + CORE_W'(bias_core);
      axon_word  <= AXON_FLAG | AXWORD_W'(AXON_W'(bias_axon_start + AXON_W'(bias_i)));
      last_event <= (bias_rest >> 1) == '0;
    end
  end

  // Status to the controller.
  always_comb begin
    st            = '0;
    st.action     = act_reg;
    st.clear_last = clr_addr == NEURON_AW'(NEURONS - 1);
    st.load_last  = (act_reg == ACT_LOAD_RAW) || (ld_j == FLD_CW'(FIELDS_PER_WORD - 1));
    st.div_busy   = div_busy;
    st.in_window  = (phase >= EPOCH_W'(1)) && (phase <= WINDOW) &&
                    (32'(idx_reg) < NEURONS);
    st.spike      = spike;
    st.out_free   = out_free;
    st.bias_hit   = bias_rest[0];
    st.bias_last  = bias_i == BIAS_CW'(BIAS_COUNT - 1);
  end

  // An event is only loaded when the output register is free or draining.
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_neuron || cmd.emit_bias) |-> (!out_valid || out_ready))
    else $error("event loaded over an untaken result");

  // The divider is never restarted in the middle of a division.
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // The clearing pass owns the store write port.
  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !(cmd.load_wr || cmd.pot_update || cmd.capture))
    else $error("store written during clearing pass");

  // A spike event is only emitted after the core division has finished.
  a_emit_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_neuron |-> !div_busy)
    else $error("input spike emitted with division in flight");

endmodule

`default_nettype wire

@@ design/spike_rate_encoder.sv @@
// Spike rate encoder top level: joins the sequencing controller and the
// datapath. Depends on sre_pkg, sre_ctrl, sre_dp (and sre_div through it).
//
// Usage: items enter on a valid/ready channel (action, neuron_index,
// packed_word, raw_activation, sim_time); each transfer is one item.
// Spike events leave on a valid/ready channel through one output register;
// last_event marks the final event of an item. Configuration registers are
// written through cfg_write/cfg_index/cfg_data with no wait state.
// Items are taken one at a time; in_ready stays low until an item is done.
//   load_raw writes one store entry; load_packed one store write per field.
//   neuron_step divides the timestep by the epoch length for the phase and,
//   on a spike, the neuron index by neurons_per_core for core and axon,
//   both in the one bit-per-cycle divider.
//   bias_step also takes the phase and then steps through the bias slots.
// After reset, a clearing pass writes zeros to all 2048 entries of both neuron
// stores, one entry a cycle; in_ready stays low during it.
// When the receiver stalls, the event holds in the output register; the block
// still takes the next item and stops only when it has a new event to load.
`default_nettype none

module spike_rate_encoder
  import sre_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration port.
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IW-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Item input channel.
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           action,
  input  wire logic [IDX_W-1:0]     neuron_index,
  input  wire logic [WORD_W-1:0]    packed_word,
  input  wire logic [ACT_W-1:0]     raw_activation,
  input  wire logic [TIME_W-1:0]    sim_time,
  // Spike event output channel.
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [TIME_W-1:0]         event_time,
  output logic [CHIP_W-1:0]         chip_index,
  output logic [CORE_W-1:0]         core_id,
  output logic [AXWORD_W-1:0]       axon_word,
  output logic                      last_event
);

  sre_cmd_t    cmd;
  sre_status_t st;

  // Sequencing.
  sre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Stores, arithmetic and output register.
  sre_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .neuron_index   (neuron_index),
    .packed_word    (packed_word),
    .raw_activation (raw_activation),
    .sim_time       (sim_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_time     (event_time),
    .chip_index     (chip_index),
    .core_id        (core_id),
    .axon_word      (axon_word),
    .last_event     (last_event)
  );

endmodule

`default_nettype wire
